FILE: hdl/ihc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_pkg
// Types and constants shared by the IPv4 header check and classify block.
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int HEADER_WORDS = HEADER_BYTES / 2;
    localparam int COUNT_W      = 4;

    localparam logic [COUNT_W-1:0] IDX_LENGTH   = 4'd1;
    localparam logic [COUNT_W-1:0] IDX_FLAGS    = 4'd3;
    localparam logic [COUNT_W-1:0] IDX_PROTOCOL = 4'd4;
    localparam logic [COUNT_W-1:0] LAST_COUNT   = COUNT_W'(HEADER_WORDS);

    localparam int MF_BIT = 13;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [2:0] V_BAD_SUM  = 3'd0;
    localparam logic [2:0] V_FRAGMENT = 3'd1;
    localparam logic [2:0] V_ICMP     = 3'd2;
    localparam logic [2:0] V_UDP      = 3'd3;
    localparam logic [2:0] V_TCP      = 3'd4;
    localparam logic [2:0] V_OTHER    = 3'd5;

    localparam logic [15:0] SUM_GOOD = 16'hFFFF;

    typedef struct packed {
        logic [15:0] header_word;
        logic        start_of_header;
    } hdr_word_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  protocol_number;
        logic [15:0] total_length;
    } res_word_t;

    typedef struct packed {
        logic        done;
        logic [15:0] sum;
        logic        more_fragments;
        logic [7:0]  protocol;
        logic [15:0] length;
    } hdr_status_t;

endpackage

FILE: hdl/ihc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_accum
// Ones'-complement running sum and header field capture, one word per cycle while take is high.
// ----------------------------------------------------------------------------
module ihc_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  ihc_pkg::hdr_word_t  word,
    output ihc_pkg::hdr_status_t status
);

    logic [15:0]               sum_reg, sum_next, sum_base;
    logic [ihc_pkg::COUNT_W-1:0] count_reg, count_next, count_base;
    logic                      mf_reg, mf_next;
    logic [7:0]                proto_reg, proto_next;
    logic [15:0]               len_reg, len_next;
    logic                      in_header_reg, in_header_next;
    logic                      start;
    logic                      active;
    logic                      done;
    logic [16:0]               raw_sum;

    assign start  = word.start_of_header;
    assign active = take && (start || in_header_reg);

    always_comb
    begin
        sum_base   = start ? 16'd0 : sum_reg;
        count_base = start ? '0 : count_reg;
        mf_next    = start ? 1'b0 : mf_reg;
        proto_next = start ? 8'd0 : proto_reg;
        len_next   = start ? 16'd0 : len_reg;

        // end-around carry
        raw_sum  = {1'b0, sum_base} + {1'b0, word.header_word};
        sum_next = raw_sum[15:0] + {15'd0, raw_sum[16]};

        case (count_base)
            ihc_pkg::IDX_LENGTH:   len_next   = word.header_word;
            ihc_pkg::IDX_FLAGS:    mf_next    = word.header_word[ihc_pkg::MF_BIT];
            ihc_pkg::IDX_PROTOCOL: proto_next = word.header_word[7:0];
            default:               ;
        endcase

        count_next     = count_base + 1'b1;
        done           = active && (count_next >= ihc_pkg::LAST_COUNT);
        in_header_next = !done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            mf_reg        <= 1'b0;
            proto_reg     <= '0;
            len_reg       <= '0;
            in_header_reg <= 1'b0;
        end
        else if (active)
        begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            mf_reg        <= mf_next;
            proto_reg     <= proto_next;
            len_reg       <= len_next;
            in_header_reg <= in_header_next;
        end
    end

    assign status.done           = done;
    assign status.sum            = sum_next;
    assign status.more_fragments = mf_next;
    assign status.protocol       = proto_next;
    assign status.length         = len_next;

endmodule

FILE: hdl/ihc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_classify
// Verdict decode on the last header word and the result output register.
// ----------------------------------------------------------------------------
module ihc_classify (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ihc_pkg::hdr_status_t status,
    output logic                 ready,
    output logic                 res_valid,
    input  logic                 res_stall,
    output ihc_pkg::res_word_t   res_word
);

    logic               valid_reg, valid_next;
    ihc_pkg::res_word_t word_reg, word_next;

    always_comb
    begin
        word_next.protocol_number = status.protocol;
        word_next.total_length    = status.length;
        if (status.sum != ihc_pkg::SUM_GOOD)
            word_next.verdict = ihc_pkg::V_BAD_SUM;
        else if (status.more_fragments)
            word_next.verdict = ihc_pkg::V_FRAGMENT;
        else
        begin
            case (status.protocol)
                ihc_pkg::PROTO_ICMP: word_next.verdict = ihc_pkg::V_ICMP;
                ihc_pkg::PROTO_UDP:  word_next.verdict = ihc_pkg::V_UDP;
                ihc_pkg::PROTO_TCP:  word_next.verdict = ihc_pkg::V_TCP;
                default:             word_next.verdict = ihc_pkg::V_OTHER;
            endcase
        end
    end

    assign ready = !valid_reg || !res_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (status.done)
            valid_next = 1'b1;
        else if (!res_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
            word_reg <= word_next;
    end

    assign res_valid = valid_reg;
    assign res_word  = word_reg;

    // a new result never overwrites one still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> ready)
        else $error("result overwritten while stalled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |=> res_valid)
        else $error("loaded result not presented");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> res_valid)
        else $error("stalled result dropped");

endmodule

FILE: hdl/ipv4_header_check_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_check_classify
// Verifies the IPv4 header checksum and classifies the datagram.
// ----------------------------------------------------------------------------
// usage
//   hdr channel: one 16-bit header word per accepted transfer, first byte in
//   the upper half; start_of_header marks word zero of a new header. words
//   outside a header are dropped, a new start abandons an open header
//   res channel: one result word per complete 20-byte header carrying the
//   verdict, protocol byte and total length
// timing
//   one header word per cycle sustained while hdr_stall is low; the checksum adder and the verdict
//   decode sit between the header state registers and the result register;
//   the result is registered and appears in the cycle after the tenth header word is accepted
// reset
//   header state and the result valid are cleared, block starts idle
// stall
//   a result held under res_stall stays on the port; hdr_stall is raised
//   only while a held result is stalled, so words keep flowing otherwise
// ----------------------------------------------------------------------------
module ipv4_header_check_classify (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hdr_valid,
    output logic               hdr_stall,
    input  ihc_pkg::hdr_word_t hdr_word,
    output logic               res_valid,
    input  logic               res_stall,
    output ihc_pkg::res_word_t res_word
);

    ihc_pkg::hdr_status_t status;
    logic                 ready;
    logic                 take;

    assign hdr_stall = !ready;
    assign take      = hdr_valid && ready;

    ihc_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .word   (hdr_word),
        .status (status)
    );

    ihc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .ready     (ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule
